// ----- sv/hmfr_pkg.sv -----
// Shared types, constants and register codes for the HART master frame receiver.
package hmfr_pkg;

    localparam int DEF_MAX_FRAME_BYTES = 32;

    localparam int BYTE_W     = 8;
    localparam int CFG_W      = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int PREAMBLE_W = 5;
    localparam int LAST_W     = 9;
    localparam int IDX_W      = 5;
    localparam int STATUS_W   = 3;

    localparam logic [BYTE_W-1:0]     PREAMBLE_BYTE = 8'hFF;
    localparam logic [PREAMBLE_W-1:0] PREAMBLE_MAX  = 5'd31;
    localparam logic [LAST_W-1:0]     LAST_UNKNOWN  = 9'h1FF;
    localparam logic [BYTE_W-1:0]     POLL_MASK     = 8'h0F;
    localparam logic [BYTE_W-1:0]     MFR_MASK      = 8'h3F;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MIN_PREAMBLES     = 3'd0,
        REG_FILTER_ADDRESS    = 3'd1,
        REG_POLL_ADDRESS      = 3'd2,
        REG_MANUFACTURER_CODE = 3'd3,
        REG_DEVICE_KIND       = 3'd4,
        REG_UNIQUE_ID_BASE    = 3'd5,
        REG_SHORT_DELIMITER   = 3'd6,
        REG_LONG_DELIMITER    = 3'd7
    } cfg_index_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK        = 3'd0,
        STATUS_BAD_CHECK = 3'd1,
        STATUS_ADDR_MISS = 3'd2,
        STATUS_BAD_DELIM = 3'd3,
        STATUS_OVERLONG  = 3'd4
    } frame_status_t;

    typedef struct packed {
        logic [PREAMBLE_W-1:0] min_preambles;
        logic                  filter_address;
        logic [3:0]            poll_address;
        logic [5:0]            manufacturer_code;
        logic [BYTE_W-1:0]     device_kind;
        logic [CFG_W-1:0]      unique_id_base;
        logic [BYTE_W-1:0]     short_delimiter;
        logic [BYTE_W-1:0]     long_delimiter;
    } cfg_t;

    typedef struct packed {
        logic [BYTE_W-1:0]   data_byte;
        logic [IDX_W-1:0]    byte_index;
        logic                long_format;
        logic                frame_end;
        logic [STATUS_W-1:0] frame_status;
        logic                accepted;
    } result_t;

endpackage

// ----- sv/hmfr_if.sv -----
// Valid/ready channel interfaces for received words and frame result words.
interface hmfr_req_if import hmfr_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              req_type;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output req_type, output rx_byte, input ready);
    modport sink (input valid, input req_type, input rx_byte, output ready);
endinterface

interface hmfr_res_if import hmfr_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [BYTE_W-1:0]   data_byte;
    logic [IDX_W-1:0]    byte_index;
    logic                long_format;
    logic                frame_end;
    logic [STATUS_W-1:0] frame_status;
    logic                accepted;

    modport source (output valid, output data_byte, output byte_index, output long_format,
                    output frame_end, output frame_status, output accepted, input ready);
    modport sink (input valid, input data_byte, input byte_index, input long_format,
                  input frame_end, input frame_status, input accepted, output ready);
endinterface

// ----- sv/hmfr_frame.sv -----
// Frame tracking state and the combinational decode of one received word.
module hmfr_frame import hmfr_pkg::*; #(
    parameter int MAX_FRAME_BYTES = DEF_MAX_FRAME_BYTES
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic              req_type,
    input  logic [BYTE_W-1:0] rx_byte,
    input  cfg_t              cfg,
    output logic              res_valid,
    output result_t           res
);

    localparam int POS_W = $clog2(MAX_FRAME_BYTES);

    logic [PREAMBLE_W-1:0] preamble_count_reg, preamble_count_next;
    logic                  in_frame_reg, in_frame_next;
    logic [POS_W-1:0]      position_reg, position_next;
    logic [LAST_W-1:0]     last_position_reg, last_position_next;
    logic [BYTE_W-1:0]     running_xor_reg, running_xor_next;
    logic                  is_long_reg, is_long_next;
    logic                  address_ok_reg, address_ok_next;

    logic [LAST_W-1:0] last_calc;
    logic              addr_match;
    logic              count_pos;
    logic [BYTE_W-1:0] id_low;

    assign id_low    = cfg.unique_id_base[7:0] + {4'd0, cfg.poll_address};
    assign last_calc = LAST_W'(position_reg) + LAST_W'(rx_byte) + LAST_W'(1);
    assign count_pos = is_long_reg ? (position_reg == POS_W'(7))
                                   : (position_reg == POS_W'(3));

    // Address byte check for the current position of the frame.
    always_comb
    begin
        addr_match = 1'b1;
        if (!is_long_reg)
        begin
            if (position_reg == POS_W'(1))
                addr_match = ((rx_byte & POLL_MASK) == {4'd0, cfg.poll_address});
        end
        else
        begin
            if (position_reg == POS_W'(1))
                addr_match = ((rx_byte & MFR_MASK) == {2'd0, cfg.manufacturer_code});
            else if (position_reg == POS_W'(2))
                addr_match = (rx_byte == cfg.device_kind);
            else if (position_reg == POS_W'(3))
                addr_match = (rx_byte == cfg.unique_id_base[23:16]);
            else if (position_reg == POS_W'(4))
                addr_match = (rx_byte == cfg.unique_id_base[15:8]);
            else if (position_reg == POS_W'(5))
                addr_match = (rx_byte == id_low);
        end
    end

    always_comb
    begin
        preamble_count_next = preamble_count_reg;
        in_frame_next       = in_frame_reg;
        position_next       = position_reg;
        last_position_next  = last_position_reg;
        running_xor_next    = running_xor_reg;
        is_long_next        = is_long_reg;
        address_ok_next     = address_ok_reg;

        res_valid        = 1'b0;
        res.data_byte    = rx_byte;
        res.byte_index   = IDX_W'(position_reg);
        res.long_format  = is_long_reg;
        res.frame_end    = 1'b0;
        res.frame_status = STATUS_OK;
        res.accepted     = 1'b0;

        if (req_type)
        begin
            preamble_count_next = '0;
            in_frame_next       = 1'b0;
            position_next       = '0;
            last_position_next  = LAST_UNKNOWN;
            running_xor_next    = '0;
            is_long_next        = 1'b0;
            address_ok_next     = 1'b1;
        end
        else if (!in_frame_reg)
        begin
            res.byte_index  = '0;
            if (rx_byte == PREAMBLE_BYTE)
            begin
                if (preamble_count_reg != PREAMBLE_MAX)
                    preamble_count_next = preamble_count_reg + PREAMBLE_W'(1);
            end
            else if (preamble_count_reg < cfg.min_preambles)
            begin
                preamble_count_next = '0;
            end
            else
            begin
                preamble_count_next = '0;
                res_valid           = 1'b1;
                if (rx_byte == cfg.short_delimiter || rx_byte == cfg.long_delimiter)
                begin
                    // The short format wins when both delimiters are equal.
                    is_long_next       = (rx_byte != cfg.short_delimiter);
                    in_frame_next      = 1'b1;
                    position_next      = POS_W'(1);
                    last_position_next = LAST_UNKNOWN;
                    running_xor_next   = rx_byte;
                    address_ok_next    = 1'b1;
                    res.long_format    = (rx_byte != cfg.short_delimiter);
                end
                else
                begin
                    res.long_format  = 1'b0;
                    res.frame_end    = 1'b1;
                    res.frame_status = STATUS_BAD_DELIM;
                    position_next    = '0;
                    running_xor_next = '0;
                    is_long_next     = 1'b0;
                    address_ok_next  = 1'b1;
                end
            end
        end
        else
        begin
            res_valid = 1'b1;
            if (LAST_W'(position_reg) == last_position_reg)
            begin
                res.frame_end = 1'b1;
                if (running_xor_reg != rx_byte)
                    res.frame_status = STATUS_BAD_CHECK;
                else if (cfg.filter_address && !address_ok_reg)
                    res.frame_status = STATUS_ADDR_MISS;
                else
                    res.accepted = 1'b1;
                in_frame_next      = 1'b0;
                position_next      = '0;
                last_position_next = LAST_UNKNOWN;
                running_xor_next   = '0;
                is_long_next       = 1'b0;
                address_ok_next    = 1'b1;
            end
            else if (count_pos
                     && ({1'b0, last_calc} >= (LAST_W + 1)'(MAX_FRAME_BYTES)))
            begin
                res.frame_end      = 1'b1;
                res.frame_status   = STATUS_OVERLONG;
                in_frame_next      = 1'b0;
                position_next      = '0;
                last_position_next = LAST_UNKNOWN;
                running_xor_next   = '0;
                is_long_next       = 1'b0;
                address_ok_next    = 1'b1;
            end
            else
            begin
                running_xor_next = running_xor_reg ^ rx_byte;
                address_ok_next  = address_ok_reg && addr_match;
                position_next    = position_reg + POS_W'(1);
                if (count_pos)
                    last_position_next = last_calc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            preamble_count_reg <= '0;
            in_frame_reg       <= 1'b0;
            position_reg       <= '0;
            last_position_reg  <= LAST_UNKNOWN;
            running_xor_reg    <= '0;
            is_long_reg        <= 1'b0;
            address_ok_reg     <= 1'b1;
        end
        else if (step)
        begin
            preamble_count_reg <= preamble_count_next;
            in_frame_reg       <= in_frame_next;
            position_reg       <= position_next;
            last_position_reg  <= last_position_next;
            running_xor_reg    <= running_xor_next;
            is_long_reg        <= is_long_next;
            address_ok_reg     <= address_ok_next;
        end
    end

endmodule

// ----- sv/hart_master_frame_receiver_core.sv -----
// Top level of the HART master frame receiver: registers, word staging and result output.
//
//  channel | dir | handshake    | payload
//  --------+-----+--------------+------------------------------------------------------
//  req     | in  | valid/ready  | req_type, rx_byte
//  res     | out | valid/ready  | data_byte, byte_index, long_format, frame_end,
//          |     |              | frame_status, accepted
//  cfg     | in  | cfg_we       | cfg_index, cfg_data
//
// Each word is decoded combinationally while it sits in the input register, and its result
// is written to the result register when the word advances out of the input register.
// One word per cycle is sustained unless decode stalls; words with no result advance too.
// The input register can take a word while the result register holds a word not yet read,
// and decode stalls only when the result register is full and res.ready is low.
// Reset clears the frame state to preamble hunting and the registers to their defaults.
module hart_master_frame_receiver_core import hmfr_pkg::*; #(
    parameter int MAX_FRAME_BYTES = DEF_MAX_FRAME_BYTES
) (
    input  logic                 clk,
    input  logic                 rst_n,
    hmfr_req_if.sink             req,
    hmfr_res_if.source           res,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    cfg_t cfg_reg;

    logic              in_valid_reg;
    logic              in_type_reg;
    logic [BYTE_W-1:0] in_byte_reg;

    logic    out_valid_reg;
    result_t out_reg;

    logic    advance;
    logic    req_take;
    logic    step_valid;
    result_t step_res;

    assign advance   = in_valid_reg && (!out_valid_reg || res.ready);
    assign req.ready = !in_valid_reg || advance;
    assign req_take  = req.valid && req.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_preambles     <= 5'd5;
            cfg_reg.filter_address    <= 1'b0;
            cfg_reg.poll_address      <= '0;
            cfg_reg.manufacturer_code <= '0;
            cfg_reg.device_kind       <= '0;
            cfg_reg.unique_id_base    <= '0;
            cfg_reg.short_delimiter   <= 8'd2;
            cfg_reg.long_delimiter    <= 8'd130;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                REG_MIN_PREAMBLES:     cfg_reg.min_preambles     <= cfg_data[PREAMBLE_W-1:0];
                REG_FILTER_ADDRESS:    cfg_reg.filter_address    <= cfg_data[0];
                REG_POLL_ADDRESS:      cfg_reg.poll_address      <= cfg_data[3:0];
                REG_MANUFACTURER_CODE: cfg_reg.manufacturer_code <= cfg_data[5:0];
                REG_DEVICE_KIND:       cfg_reg.device_kind       <= cfg_data[BYTE_W-1:0];
                REG_UNIQUE_ID_BASE:    cfg_reg.unique_id_base    <= cfg_data;
                REG_SHORT_DELIMITER:   cfg_reg.short_delimiter   <= cfg_data[BYTE_W-1:0];
                REG_LONG_DELIMITER:    cfg_reg.long_delimiter    <= cfg_data[BYTE_W-1:0];
                default:               cfg_reg                   <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (req_take)
            in_valid_reg <= 1'b1;
        else if (advance)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (req_take)
        begin
            in_type_reg <= req.req_type;
            in_byte_reg <= req.rx_byte;
        end
    end

    hmfr_frame #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_frame (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .req_type  (in_type_reg),
        .rx_byte   (in_byte_reg),
        .cfg       (cfg_reg),
        .res_valid (step_valid),
        .res       (step_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= step_valid;
        else if (res.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance && step_valid)
            out_reg <= step_res;
    end

    assign res.valid        = out_valid_reg;
    assign res.data_byte    = out_reg.data_byte;
    assign res.byte_index   = out_reg.byte_index;
    assign res.long_format  = out_reg.long_format;
    assign res.frame_end    = out_reg.frame_end;
    assign res.frame_status = out_reg.frame_status;
    assign res.accepted     = out_reg.accepted;

endmodule
